// ----- hw/rtl/ip_fragment_reassembly_tracker_assert.svh -----
// Assertion macros used by the reassembly tracker back stage.
`ifndef IP_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IP_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FRA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fra_pkg.sv -----
// Types and constants of the fragment reassembly tracker.
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;

  localparam logic [3:0] KIND_STORED    = 4'd0;
  localparam logic [3:0] KIND_DELIVERED = 4'd1;
  localparam logic [3:0] KIND_COMPLETE  = 4'd2;
  localparam logic [3:0] KIND_DUPLICATE = 4'd3;
  localparam logic [3:0] KIND_BAD_CSUM  = 4'd4;
  localparam logic [3:0] KIND_NOT_OURS  = 4'd5;
  localparam logic [3:0] KIND_NO_ROOM   = 4'd6;
  localparam logic [3:0] KIND_REMOVED   = 4'd7;
  localparam logic [3:0] KIND_EXPIRED   = 4'd8;

  localparam int MAX_RESULTS  = 17;
  localparam int MAX_REMOVALS = 16;

  localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd0;
  localparam logic [1:0] REG_IGNORE_CSUM   = 2'd1;
  localparam logic [1:0] REG_LIFETIME      = 2'd2;

  localparam int PIECE_W = 34;

  typedef struct packed {
    logic [31:0] local_address;
    logic        ignore_bad_checksum;
    logic [7:0]  lifetime;
  } cfg_t;

  typedef struct packed {
    logic        is_tick;
    logic        drop;
    logic [3:0]  dkind;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] id;
    logic [7:0]  proto;
    logic [15:0] len;
    logic [15:0] off;
    logic        more;
    logic [16:0] fend;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  ctx;
    logic [15:0] po;
    logic [15:0] pl;
    logic [15:0] tf;
    logic [16:0] dl;
    logic [7:0]  proto;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fra_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fra_fifo.sv -----
// Small flop-based queue used for the tracker's command and result queues.
`timescale 1ns / 1ps
`default_nettype none
module fra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             rd,
  output      logic [WIDTH-1:0] rdata,
  output      logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fra_front.sv -----
// Front stage: decodes and classifies incoming header items and ticks.
`timescale 1ns / 1ps
`default_nettype none
module fra_front import fra_pkg::*; (
  input  wire logic        command,
  input  wire logic [31:0] source_address,
  input  wire logic [31:0] destination_address,
  input  wire logic [15:0] datagram_id,
  input  wire logic [7:0]  protocol_number,
  input  wire logic [3:0]  header_words,
  input  wire logic [15:0] total_length,
  input  wire logic [15:0] flags_offset,
  input  wire logic        checksum_ok,
  input  wire cfg_t        cfg,
  output      cmd_t        cmd
);

  logic [15:0] hlen;
  logic [15:0] off;
  logic [15:0] len;
  logic [17:0] sum;

  always_comb begin
    hlen = {10'd0, header_words, 2'b00};
    off  = {flags_offset[12:0], 3'b000};
    len  = (total_length > hlen) ? total_length - hlen : 16'd0;
    sum  = {2'b00, off} + {2'b00, len};

    cmd.is_tick = command;
    cmd.src     = source_address;
    cmd.dst     = destination_address;
    cmd.id      = datagram_id;
    cmd.proto   = protocol_number;
    cmd.len     = len;
    cmd.off     = off;
    cmd.more    = flags_offset[13];
    cmd.fend    = (sum > 18'h10000) ? 17'h10000 : sum[16:0];
    cmd.drop    = 1'b0;
    cmd.dkind   = KIND_BAD_CSUM;
    if (!checksum_ok && !cfg.ignore_bad_checksum) begin
      cmd.drop  = 1'b1;
      cmd.dkind = KIND_BAD_CSUM;
    end else if (destination_address != cfg.local_address) begin
      cmd.drop  = 1'b1;
      cmd.dkind = KIND_NOT_OURS;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fra_back.sv -----
// Back stage: context table, piece list walk, aging and result generation.
`timescale 1ns / 1ps
`default_nettype none
`include "ip_fragment_reassembly_tracker_assert.svh"
module fra_back import fra_pkg::*; #(
  parameter int CONTEXTS = 8,
  parameter int PIECES_PER_CONTEXT = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] lifetime,
  input  wire logic       cmd_empty,
  input  wire cmd_t       cmd_data,
  output      logic       cmd_pop,
  input  wire logic       out_full,
  output      logic       opush,
  output      res_t       ores
);

  localparam int CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int IW = $clog2(CONTEXTS + 1);
  localparam int NW = $clog2(PIECES_PER_CONTEXT + 1);
  localparam int DEPTH = 2 * CONTEXTS * PIECES_PER_CONTEXT;
  localparam int AW = $clog2(DEPTH);
  localparam logic [NW-1:0] PPC_N = NW'(PIECES_PER_CONTEXT);

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_SCAN   = 2'd1;
  localparam logic [1:0] PH_AFTER  = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOOKUP = 9'b000000010,
    S_RD     = 9'b000000100,
    S_PROC   = 9'b000001000,
    S_INS    = 9'b000010000,
    S_KEEP   = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_TICK   = 9'b100000000
  } st_t;

  function automatic logic [AW-1:0] paddr_of(input logic [CW-1:0] c, input logic b,
                                             input logic [NW-1:0] j);
    paddr_of = AW'((int'(c) * 2 + int'(b)) * PIECES_PER_CONTEXT + int'(j));
  endfunction

  // context table
  logic [CONTEXTS-1:0] valid_r;
  logic [CONTEXTS-1:0] bank_r;
  logic [NW-1:0]       cnt_r   [CONTEXTS];
  logic [31:0]         csrc_r  [CONTEXTS];
  logic [31:0]         cdst_r  [CONTEXTS];
  logic [15:0]         cid_r   [CONTEXTS];
  logic [7:0]          cpro_r  [CONTEXTS];
  logic [7:0]          age_r   [CONTEXTS];

  st_t           state_r, state_nxt;
  cmd_t          item_r, item_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [NW-1:0] n_r, n_nxt, j_r, j_nxt, wp_r, wp_nxt, rem_r, rem_nxt;
  logic [15:0]   s_r, s_nxt, front_r, front_nxt;
  logic [16:0]   e_r, e_nxt, pend_r, pend_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          alive_r, alive_nxt, noroom_r, noroom_nxt, ok_r, ok_nxt;
  logic          lmore_r, lmore_nxt, insfin_r, insfin_nxt;
  logic [PIECE_W-1:0] p_r, p_nxt;
  res_t          fin_r, fin_nxt;
  logic [IW-1:0] ci_r, ci_nxt;
  logic [4:0]    xcnt_r, xcnt_nxt;
  logic          pv_r, pv_nxt;
  logic [CW-1:0] pc_r, pc_nxt;

  // table update controls
  logic          open_en, clr_en, setcnt_en, age_en;
  logic [CW-1:0] open_c, clr_c, age_c;
  logic [NW-1:0] setcnt_v;
  logic [7:0]    age_v;

  // piece memory
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [PIECE_W-1:0] ram_wdata, ram_rdata;

  // lookup
  logic          found_v, free_v;
  logic [CW-1:0] found_c, free_c;

  always_comb begin
    found_v = 1'b0;
    free_v  = 1'b0;
    found_c = '0;
    free_c  = '0;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (valid_r[i] && csrc_r[i] == item_r.src && cdst_r[i] == item_r.dst &&
          cid_r[i] == item_r.id && cpro_r[i] == item_r.proto) begin
        found_v = 1'b1;
        found_c = CW'(i);
      end
      if (!valid_r[i]) begin
        free_v = 1'b1;
        free_c = CW'(i);
      end
    end
  end

  always_comb begin
    logic [16:0]   ps, pe, s17;
    logic          do_rem, do_ins, stall;
    logic [1:0]    ph_t;
    logic [16:0]   e_t;
    logic [15:0]   s_t, front_t;
    logic          alive_t;
    logic [CW-1:0] cc, ti;
    logic [16:0]   ws, we_v;

    state_nxt  = state_r;
    item_nxt   = item_r;
    c_nxt      = c_r;
    n_nxt      = n_r;
    j_nxt      = j_r;
    wp_nxt     = wp_r;
    rem_nxt    = rem_r;
    s_nxt      = s_r;
    front_nxt  = front_r;
    e_nxt      = e_r;
    pend_nxt   = pend_r;
    phase_nxt  = phase_r;
    alive_nxt  = alive_r;
    noroom_nxt = noroom_r;
    ok_nxt     = ok_r;
    lmore_nxt  = lmore_r;
    insfin_nxt = insfin_r;
    p_nxt      = p_r;
    fin_nxt    = fin_r;
    ci_nxt     = ci_r;
    xcnt_nxt   = xcnt_r;
    pv_nxt     = pv_r;
    pc_nxt     = pc_r;

    cmd_pop   = 1'b0;
    opush     = 1'b0;
    ores      = '0;
    open_en   = 1'b0;
    open_c    = '0;
    clr_en    = 1'b0;
    clr_c     = '0;
    setcnt_en = 1'b0;
    setcnt_v  = '0;
    age_en    = 1'b0;
    age_c     = '0;
    age_v     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = paddr_of(c_r, ~bank_r[c_r], wp_r);
    ram_raddr = paddr_of(c_r, bank_r[c_r], j_r);
    ram_wdata = {s_r, e_r, item_r.more};

    ps      = {1'b0, ram_rdata[33:18]};
    pe      = ram_rdata[17:1];
    s17     = {1'b0, s_r};
    do_rem  = 1'b0;
    do_ins  = 1'b0;
    stall   = 1'b0;
    ph_t    = phase_r;
    e_t     = e_r;
    s_t     = s_r;
    front_t = front_r;
    alive_t = alive_r;
    cc      = found_v ? found_c : free_c;
    ti      = ci_r[CW-1:0];
    ws      = {1'b0, s_r};
    we_v    = e_r;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          item_nxt = cmd_data;
          if (cmd_data.is_tick) begin
            ci_nxt    = '0;
            xcnt_nxt  = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_TICK;
          end else if (cmd_data.drop) begin
            fin_nxt       = '0;
            fin_nxt.kind  = cmd_data.dkind;
            fin_nxt.proto = cmd_data.proto;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end

      S_LOOKUP: begin
        fin_nxt       = '0;
        fin_nxt.proto = item_r.proto;
        state_nxt     = S_DONE;
        if (!item_r.more && item_r.off == '0) begin
          if (found_v) begin
            clr_en = 1'b1;
            clr_c  = found_c;
          end
          fin_nxt.kind = KIND_DELIVERED;
          fin_nxt.dl   = {1'b0, item_r.len};
        end else if (!found_v && !free_v) begin
          fin_nxt.kind = KIND_NO_ROOM;
          fin_nxt.po   = item_r.off;
        end else begin
          if (!found_v) begin
            open_en = 1'b1;
            open_c  = free_c;
          end
          c_nxt = cc;
          if (item_r.fend <= {1'b0, item_r.off}) begin
            fin_nxt.kind = KIND_DUPLICATE;
            fin_nxt.ctx  = 3'(cc);
            fin_nxt.po   = item_r.off;
          end else begin
            n_nxt      = found_v ? cnt_r[found_c] : '0;
            j_nxt      = '0;
            wp_nxt     = '0;
            rem_nxt    = '0;
            s_nxt      = item_r.off;
            e_nxt      = item_r.fend;
            front_nxt  = '0;
            alive_nxt  = 1'b1;
            noroom_nxt = 1'b0;
            phase_nxt  = PH_BEFORE;
            ok_nxt     = 1'b1;
            pend_nxt   = '0;
            lmore_nxt  = 1'b0;
            insfin_nxt = 1'b1;
            state_nxt  = (found_v && cnt_r[found_c] != '0) ? S_RD : S_INS;
          end
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_PROC;
      end

      S_PROC: begin
        case (phase_r)
          PH_BEFORE: begin
            if (pe <= s17) begin
              ph_t = PH_BEFORE;
            end else if (e_r <= ps) begin
              do_ins = 1'b1;
              ph_t   = PH_AFTER;
            end else if (e_r < pe) begin
              if (s17 < ps) begin
                e_t    = ps;
                do_ins = 1'b1;
              end else begin
                alive_t = 1'b0;
              end
              ph_t = PH_AFTER;
            end else if (s17 <= ps) begin
              do_rem = 1'b1;
              ph_t   = PH_SCAN;
            end else if (pe < e_r) begin
              front_t = 16'(pe - s17);
              s_t     = pe[15:0];
              ph_t    = PH_SCAN;
            end else begin
              alive_t = 1'b0;
              ph_t    = PH_AFTER;
            end
          end
          PH_SCAN: begin
            if (ps < e_r) begin
              if (pe <= e_r) begin
                do_rem = 1'b1;
              end else begin
                if (ps > s17) begin
                  e_t    = ps;
                  do_ins = 1'b1;
                end else begin
                  alive_t = 1'b0;
                end
                ph_t = PH_AFTER;
              end
            end else begin
              do_ins = 1'b1;
              ph_t   = PH_AFTER;
            end
          end
          default: ph_t = phase_r;
        endcase

        stall = do_rem && int'(rem_r) < MAX_REMOVALS && out_full;
        if (!stall) begin
          phase_nxt = ph_t;
          e_nxt     = e_t;
          s_nxt     = s_t;
          front_nxt = front_t;
          alive_nxt = alive_t;
          p_nxt     = ram_rdata;
          j_nxt     = j_r + NW'(1);
          if (do_rem) begin
            if (int'(rem_r) < MAX_REMOVALS) begin
              opush      = 1'b1;
              ores.kind  = KIND_REMOVED;
              ores.ctx   = 3'(c_r);
              ores.po    = ps[15:0];
              ores.pl    = 16'(pe - ps);
              ores.proto = item_r.proto;
            end
            rem_nxt = rem_r + NW'(1);
            if (j_r + NW'(1) < n_r) begin
              ram_re    = 1'b1;
              ram_raddr = paddr_of(c_r, bank_r[c_r], j_r + NW'(1));
              state_nxt = S_PROC;
            end else begin
              insfin_nxt = 1'b1;
              state_nxt  = S_INS;
            end
          end else if (do_ins) begin
            insfin_nxt = 1'b0;
            state_nxt  = S_INS;
          end else begin
            state_nxt = S_KEEP;
          end
        end
      end

      S_INS: begin
        if (n_r == PPC_N && rem_r == '0) begin
          noroom_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ok_nxt    = ok_r && ((wp_r == '0) ? (ws == '0) : (ws == pend_r));
          pend_nxt  = we_v;
          lmore_nxt = item_r.more;
          wp_nxt    = wp_r + NW'(1);
        end
        state_nxt = insfin_r ? S_FIN : S_KEEP;
      end

      S_KEEP: begin
        ws        = {1'b0, p_r[33:18]};
        we_v      = p_r[17:1];
        ram_we    = 1'b1;
        ram_wdata = p_r;
        ok_nxt    = ok_r && ((wp_r == '0) ? (ws == '0) : (ws == pend_r));
        pend_nxt  = we_v;
        lmore_nxt = p_r[0];
        wp_nxt    = wp_r + NW'(1);
        if (j_r < n_r) begin
          ram_re    = 1'b1;
          state_nxt = S_PROC;
        end else if (phase_r != PH_AFTER && alive_r) begin
          insfin_nxt = 1'b1;
          state_nxt  = S_INS;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_full) begin
          opush      = 1'b1;
          ores.ctx   = 3'(c_r);
          ores.proto = item_r.proto;
          ores.last  = 1'b1;
          setcnt_en  = 1'b1;
          setcnt_v   = wp_r;
          if (!alive_r) begin
            ores.kind = KIND_DUPLICATE;
            ores.po   = item_r.off;
          end else if (noroom_r) begin
            ores.kind = KIND_NO_ROOM;
            ores.po   = item_r.off;
          end else begin
            ores.po = s_r;
            ores.pl = 16'(e_r - {1'b0, s_r});
            ores.tf = front_r;
            if (ok_r && !lmore_r) begin
              ores.kind = KIND_COMPLETE;
              ores.dl   = pend_r;
              clr_en    = 1'b1;
              clr_c     = c_r;
            end else begin
              ores.kind = KIND_STORED;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      S_DONE: begin
        if (!out_full) begin
          opush      = 1'b1;
          ores       = fin_r;
          ores.last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_TICK: begin
        if (ci_r == IW'(CONTEXTS)) begin
          if (!pv_r) begin
            state_nxt = S_IDLE;
          end else if (!out_full) begin
            opush     = 1'b1;
            ores.kind = KIND_EXPIRED;
            ores.ctx  = 3'(pc_r);
            ores.last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (valid_r[ti] && age_r[ti] <= 8'd1) begin
          if (int'(xcnt_r) < MAX_RESULTS) begin
            if (!(pv_r && out_full)) begin
              if (pv_r) begin
                opush     = 1'b1;
                ores.kind = KIND_EXPIRED;
                ores.ctx  = 3'(pc_r);
              end
              pv_nxt   = 1'b1;
              pc_nxt   = ti;
              xcnt_nxt = xcnt_r + 5'd1;
              clr_en   = 1'b1;
              clr_c    = ti;
              ci_nxt   = ci_r + IW'(1);
            end
          end else begin
            age_en = 1'b1;
            age_c  = ti;
            age_v  = 8'd1;
            ci_nxt = ci_r + IW'(1);
          end
        end else begin
          if (valid_r[ti]) begin
            age_en = 1'b1;
            age_c  = ti;
            age_v  = age_r[ti] - 8'd1;
          end
          ci_nxt = ci_r + IW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rem_r   <= '0;
      n_r     <= '0;
      j_r     <= '0;
      ci_r    <= '0;
      xcnt_r  <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rem_r   <= rem_nxt;
      n_r     <= n_nxt;
      j_r     <= j_nxt;
      ci_r    <= ci_nxt;
      xcnt_r  <= xcnt_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    c_r      <= c_nxt;
    s_r      <= s_nxt;
    e_r      <= e_nxt;
    front_r  <= front_nxt;
    pend_r   <= pend_nxt;
    phase_r  <= phase_nxt;
    alive_r  <= alive_nxt;
    noroom_r <= noroom_nxt;
    ok_r     <= ok_nxt;
    lmore_r  <= lmore_nxt;
    insfin_r <= insfin_nxt;
    p_r      <= p_nxt;
    fin_r    <= fin_nxt;
    pc_r     <= pc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      bank_r  <= '0;
      for (int i = 0; i < CONTEXTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (open_en) begin
        valid_r[open_c] <= 1'b1;
        cnt_r[open_c]   <= '0;
      end
      if (setcnt_en) begin
        cnt_r[c_r]  <= setcnt_v;
        bank_r[c_r] <= ~bank_r[c_r];
      end
      if (clr_en) begin
        valid_r[clr_c] <= 1'b0;
        cnt_r[clr_c]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (open_en) begin
      csrc_r[open_c] <= item_r.src;
      cdst_r[open_c] <= item_r.dst;
      cid_r[open_c]  <= item_r.id;
      cpro_r[open_c] <= item_r.proto;
      age_r[open_c]  <= lifetime;
    end
    if (age_en) begin
      age_r[age_c] <= age_v;
    end
  end

  fra_ram #(
    .WIDTH(PIECE_W),
    .DEPTH(DEPTH)
  ) u_piece_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `FRA_ASSERT_IMPL(a_push_has_room, opush, !out_full, "result pushed into a full queue")
  `FRA_ASSERT_NEXT(a_pop_leaves_idle, cmd_pop, state_r != S_IDLE, "popped item not taken up")
  `FRA_ASSERT_IMPL(a_list_bound, state_r != S_IDLE, wp_r <= PPC_N, "piece list overflow")
  `FRA_ASSERT_IMPL(a_rem_bound, state_r == S_PROC, rem_r <= j_r && j_r < n_r,
                   "walk index out of range")

endmodule
`default_nettype wire

// ----- hw/rtl/ip_fragment_reassembly_tracker.sv -----
// Top level of the IPv4 fragment reassembly tracker.
//
// Input channel: push an item (a header descriptor or a timer tick) while full
// is low. Result channel: while empty is low the oldest result sits on the out_
// ports; pop takes it. Each input item gives one or more results, the final one
// flagged by out_last; a tick that expires nothing gives none.
// The front stage decodes an item in the cycle it is pushed and queues it. The
// back stage works one item at a time: a dropped or unfragmented header needs
// no piece walk, while a fragment walks the stored pieces of its context, one
// entry at a time through the one read port of the piece RAM; a tick visits the
// contexts one at a time.
// Results go through a four-entry queue; when the receiver stops popping, the
// back stage holds once that queue fills and the input queue then fills too.
// Reset clears the control registers and all context valid bits and piece
// counts at once; no clearing pass runs. Configuration must be written over
// the APB port only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module ip_fragment_reassembly_tracker import fra_pkg::*; #(
  parameter int CONTEXTS = 8,
  parameter int PIECES_PER_CONTEXT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output      logic        full,
  input  wire logic        in_command,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic [15:0] in_datagram_id,
  input  wire logic [7:0]  in_protocol_number,
  input  wire logic [3:0]  in_header_words,
  input  wire logic [15:0] in_total_length,
  input  wire logic [15:0] in_flags_offset,
  input  wire logic        in_checksum_ok,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [3:0]  out_kind,
  output      logic [2:0]  out_context_index,
  output      logic [15:0] out_piece_offset,
  output      logic [15:0] out_piece_length,
  output      logic [15:0] out_trim_front,
  output      logic [16:0] out_datagram_length,
  output      logic [7:0]  out_protocol_out,
  output      logic        out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_empty, cmd_pop, res_full, res_push;

  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_LOCAL_ADDRESS: cfg_nxt.local_address       = pwdata;
        REG_IGNORE_CSUM:   cfg_nxt.ignore_bad_checksum = pwdata[0];
        REG_LIFETIME:      cfg_nxt.lifetime            = pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
    case (paddr[3:2])
      REG_LOCAL_ADDRESS: prdata = cfg_r.local_address;
      REG_IGNORE_CSUM:   prdata = {31'd0, cfg_r.ignore_bad_checksum};
      REG_LIFETIME:      prdata = {24'd0, cfg_r.lifetime};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_address       <= '0;
      cfg_r.ignore_bad_checksum <= 1'b0;
      cfg_r.lifetime            <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fra_front u_front (
    .command             (in_command),
    .source_address      (in_source_address),
    .destination_address (in_destination_address),
    .datagram_id         (in_datagram_id),
    .protocol_number     (in_protocol_number),
    .header_words        (in_header_words),
    .total_length        (in_total_length),
    .flags_offset        (in_flags_offset),
    .checksum_ok         (in_checksum_ok),
    .cfg                 (cfg_r),
    .cmd                 (cmd_in)
  );

  fra_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (push),
    .wdata (cmd_in),
    .full  (full),
    .rd    (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  fra_back #(
    .CONTEXTS           (CONTEXTS),
    .PIECES_PER_CONTEXT (PIECES_PER_CONTEXT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .lifetime  (cfg_r.lifetime),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .opush     (res_push),
    .ores      (res_in)
  );

  fra_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_push),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_kind            = res_head.kind;
  assign out_context_index   = res_head.ctx;
  assign out_piece_offset    = res_head.po;
  assign out_piece_length    = res_head.pl;
  assign out_trim_front      = res_head.tf;
  assign out_datagram_length = res_head.dl;
  assign out_protocol_out    = res_head.proto;
  assign out_last            = res_head.last;

endmodule
`default_nettype wire

// ----- dv/tb_ip_fragment_reassembly_tracker.sv -----
// Self-checking testbench for the IPv4 fragment reassembly tracker.
`timescale 1ns / 1ps
`default_nettype none
module tb_ip_fragment_reassembly_tracker import fra_pkg::*; ();

  localparam int NCTX = 8;
  localparam int NPC = 16;
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] id;
    logic [7:0]  proto;
    logic [3:0]  hwords;
    logic [15:0] tlen;
    logic [15:0] fo;
    logic        csok;
  } hdr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  hdr_t drv = '0;
  wire full, empty, pready, out_last;
  wire [31:0] prdata;
  wire [3:0] out_kind;
  wire [2:0] out_context_index;
  wire [15:0] out_piece_offset, out_piece_length, out_trim_front;
  wire [16:0] out_datagram_length;
  wire [7:0] out_protocol_out;

  ip_fragment_reassembly_tracker DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_command(drv.command), .in_source_address(drv.src),
    .in_destination_address(drv.dst), .in_datagram_id(drv.id),
    .in_protocol_number(drv.proto), .in_header_words(drv.hwords),
    .in_total_length(drv.tlen), .in_flags_offset(drv.fo),
    .in_checksum_ok(drv.csok), .empty(empty), .pop(pop),
    .out_kind(out_kind), .out_context_index(out_context_index),
    .out_piece_offset(out_piece_offset), .out_piece_length(out_piece_length),
    .out_trim_front(out_trim_front), .out_datagram_length(out_datagram_length),
    .out_protocol_out(out_protocol_out), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] my_addr;
  logic        lax_csum;
  logic [7:0]  life;
  logic        cv [NCTX];
  logic [31:0] csrc [NCTX], cdst [NCTX];
  logic [15:0] cid [NCTX];
  logic [7:0]  cpro [NCTX], cage [NCTX];
  int          pcnt [NCTX];
  int          ps [NCTX][NPC], pe [NCTX][NPC];
  logic        pm [NCTX][NPC];

  hdr_t pending_items[$];
  res_t expected_results[$];
  int errors = 0;
  int sent = 0;
  bit calm = 0;
  int hold_off = 0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  function automatic void add_res(input logic [3:0] k, input int ctx, input int po,
                                  input int pl, input int tf, input int dl,
                                  input logic [7:0] pr);
    res_t r;
    r.kind = k; r.ctx = ctx[2:0]; r.po = po[15:0]; r.pl = pl[15:0];
    r.tf = tf[15:0]; r.dl = dl[16:0]; r.proto = pr; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void drop_piece(input int c, input int p);
    for (int i = p; i + 1 < pcnt[c]; i++) begin
      ps[c][i] = ps[c][i+1]; pe[c][i] = pe[c][i+1]; pm[c][i] = pm[c][i+1];
    end
    pcnt[c]--;
  endfunction

  function automatic int done_length(input int c);
    int n;
    n = pcnt[c];
    if (n == 0 || ps[c][0] != 0) return 0;
    for (int i = 1; i < n; i++) if (ps[c][i] != pe[c][i-1]) return 0;
    if (pm[c][n-1]) return 0;
    return pe[c][n-1];
  endfunction

  function automatic void predict_reassembly(input hdr_t h);
    int nres, found, len, off, s, e, front, n, pos, k, tot, hl;
    bit more, alive;
    nres = 0; found = -1; front = 0; pos = 0;
    if (h.command == CMD_TICK) begin
      for (int c = 0; c < NCTX; c++) begin
        if (!cv[c]) continue;
        if (cage[c] <= 1) begin
          if (nres < MAX_RESULTS) begin
            cv[c] = 0; pcnt[c] = 0; nres++;
            add_res(KIND_EXPIRED, c, 0, 0, 0, 0, 8'd0);
          end else cage[c] = 1;
        end else cage[c]--;
      end
      if (nres > 0) expected_results[$].last = 1'b1;
      return;
    end
    if (!h.csok && !lax_csum) begin
      add_res(KIND_BAD_CSUM, 0, 0, 0, 0, 0, h.proto);
      expected_results[$].last = 1'b1;
      return;
    end
    if (h.dst != my_addr) begin
      add_res(KIND_NOT_OURS, 0, 0, 0, 0, 0, h.proto);
      expected_results[$].last = 1'b1;
      return;
    end
    hl = 4 * int'(h.hwords);
    len = (int'(h.tlen) > hl) ? int'(h.tlen) - hl : 0;
    more = h.fo[13];
    off = int'({h.fo[12:0], 3'b000});
    for (int c = 0; c < NCTX; c++)
      if (found < 0 && cv[c] && csrc[c] == h.src && cdst[c] == h.dst &&
          cid[c] == h.id && cpro[c] == h.proto) found = c;
    if (!more && off == 0) begin
      if (found >= 0) begin
        cv[found] = 0; pcnt[found] = 0;
      end
      add_res(KIND_DELIVERED, 0, 0, 0, 0, len, h.proto);
      expected_results[$].last = 1'b1;
      return;
    end
    if (found < 0) begin
      for (int c = 0; c < NCTX; c++) if (found < 0 && !cv[c]) found = c;
      if (found < 0) begin
        add_res(KIND_NO_ROOM, 0, off, 0, 0, 0, h.proto);
        expected_results[$].last = 1'b1;
        return;
      end
      cv[found] = 1; csrc[found] = h.src; cdst[found] = h.dst;
      cid[found] = h.id; cpro[found] = h.proto; cage[found] = life;
      pcnt[found] = 0;
    end
    s = off; e = off + len;
    if (e > 65536) e = 65536;
    alive = e > s;
    n = pcnt[found];
    if (alive) begin
      k = 0;
      while (k < n && pe[found][k] <= s) k++;
      if (k == n || e <= ps[found][k]) pos = k;
      else if (e < pe[found][k]) begin
        if (s < ps[found][k]) begin
          e = ps[found][k]; pos = k;
        end else alive = 0;
      end else begin
        if (s <= ps[found][k]) begin
          if (nres < MAX_RESULTS - 1) begin
            nres++;
            add_res(KIND_REMOVED, found, ps[found][k], pe[found][k] - ps[found][k],
                    0, 0, h.proto);
          end
          drop_piece(found, k);
          pos = k;
        end else begin
          if (pe[found][k] < e) begin
            front = pe[found][k] - s; s = pe[found][k];
          end else alive = 0;
          pos = k + 1;
        end
        while (alive && pos < pcnt[found] && ps[found][pos] < e) begin
          if (pe[found][pos] <= e) begin
            if (nres < MAX_RESULTS - 1) begin
              nres++;
              add_res(KIND_REMOVED, found, ps[found][pos],
                      pe[found][pos] - ps[found][pos], 0, 0, h.proto);
            end
            drop_piece(found, pos);
          end else begin
            if (ps[found][pos] > s) e = ps[found][pos];
            else alive = 0;
            break;
          end
        end
      end
    end
    if (!alive) add_res(KIND_DUPLICATE, found, off, 0, 0, 0, h.proto);
    else if (pcnt[found] >= NPC) add_res(KIND_NO_ROOM, found, off, 0, 0, 0, h.proto);
    else begin
      n = pcnt[found];
      for (int i = n; i > pos; i--) begin
        ps[found][i] = ps[found][i-1]; pe[found][i] = pe[found][i-1];
        pm[found][i] = pm[found][i-1];
      end
      ps[found][pos] = s; pe[found][pos] = e; pm[found][pos] = more;
      pcnt[found] = n + 1;
      tot = done_length(found);
      if (tot != 0) begin
        cv[found] = 0; pcnt[found] = 0;
        add_res(KIND_COMPLETE, found, s, e - s, front, tot, h.proto);
      end else add_res(KIND_STORED, found, s, e - s, front, 0, h.proto);
    end
    expected_results[$].last = 1'b1;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (push && !full) begin
      predict_reassembly(drv);
      sent++;
    end
    if (push && full) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      push <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      gap <= $urandom_range(0, 2);
      push <= 1'b0;
    end else if (pending_items.size() > 0) begin
      drv <= pending_items.pop_front();
      push <= 1'b1;
    end else push <= 1'b0;
  end

  // receiver hold-off countdown
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  int pgap = 0;
  always @(posedge clk) begin
    res_t w;
    if (pop && !empty) begin
      if (expected_results.size() == 0) report("unexpected result kind", out_kind, 0);
      else begin
        w = expected_results.pop_front();
        if (out_kind != w.kind) report("kind", out_kind, w.kind);
        if (out_context_index != w.ctx) report("context", out_context_index, w.ctx);
        if (out_piece_offset != w.po) report("piece_offset", out_piece_offset, w.po);
        if (out_piece_length != w.pl) report("piece_length", out_piece_length, w.pl);
        if (out_trim_front != w.tf) report("trim_front", out_trim_front, w.tf);
        if (out_datagram_length != w.dl)
          report("datagram_length", out_datagram_length, w.dl);
        if (out_protocol_out != w.proto) report("protocol", out_protocol_out, w.proto);
        if (out_last != w.last) report("last", out_last, w.last);
      end
    end
    if (hold_off > 0) begin
      pop <= 1'b0;
    end else if (pgap > 0) begin
      pgap <= pgap - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pgap <= $urandom_range(0, 2);
      pop <= 1'b0;
    end else pop <= 1'b1;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LOCAL_ADDRESS: my_addr = val;
      REG_IGNORE_CSUM: lax_csum = val[0];
      default: life = val[7:0];
    endcase
  endtask

  task automatic wait_drain();
    while (pending_items.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic hdr_t frag(input logic [31:0] s, input logic [15:0] id,
                                input int off8, input int dlen, input bit more);
    hdr_t h;
    h.command = CMD_HEADER; h.src = s; h.dst = my_addr; h.id = id;
    h.proto = 8'd17; h.hwords = 4'd5; h.tlen = 16'(20 + dlen);
    h.fo = {2'b00, more, off8[12:0]}; h.csok = 1'b1;
    return h;
  endfunction

  function automatic hdr_t tick();
    hdr_t h;
    h = '0;
    h.command = CMD_TICK;
    h.src = $urandom; h.dst = $urandom; h.fo = 16'($urandom);
    return h;
  endfunction

  function automatic hdr_t noise();
    hdr_t h;
    h.command = CMD_HEADER; h.src = $urandom; h.dst = $urandom_range(0, 1) ? my_addr : $urandom;
    h.id = 16'($urandom); h.proto = 8'($urandom); h.hwords = 4'($urandom);
    h.tlen = 16'($urandom); h.fo = 16'($urandom); h.csok = $urandom_range(0, 3) != 0;
    return h;
  endfunction

  initial begin
    hdr_t h;
    int n, o8, ln;
    logic [31:0] s;
    logic [15:0] id;
    my_addr = 0; lax_csum = 0; life = 255;
    for (int c = 0; c < NCTX; c++) begin
      cv[c] = 0; pcnt[c] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(REG_LOCAL_ADDRESS, 32'hC0A8_0001);
    cfg_write(REG_IGNORE_CSUM, 32'd0);
    cfg_write(REG_LIFETIME, 32'd3);
    // directed
    h = frag(1, 1, 0, 100, 0); h.csok = 0; pending_items.push_back(h);
    h = frag(1, 1, 0, 100, 0); h.dst = ~my_addr; pending_items.push_back(h);
    h = frag(1, 1, 0, 100, 0); h.hwords = 4'hF; h.tlen = 16'd8; pending_items.push_back(h);
    h = frag(32'hFFFF_FFFF, 16'hFFFF, 0, 16, 1); h.proto = 8'hFF; pending_items.push_back(h);
    pending_items.push_back(frag(32'hFFFF_FFFF, 16'hFFFF, 4, 16, 1));
    h = frag(32'hFFFF_FFFF, 16'hFFFF, 0, 48, 1); h.proto = 8'hFF; pending_items.push_back(h);
    h = frag(32'hFFFF_FFFF, 16'hFFFF, 1, 0, 1); h.proto = 8'hFF; pending_items.push_back(h);
    h = frag(32'hFFFF_FFFF, 16'hFFFF, 6, 8, 0); h.proto = 8'hFF; pending_items.push_back(h);
    pending_items.push_back(frag(2, 2, 8191, 65515, 1));
    pending_items.push_back(frag(2, 2, 0, 0, 0));
    for (int i = 0; i < 16; i++) pending_items.push_back(frag(3, 3, 2 * i + 1, 8, 1));
    pending_items.push_back(frag(3, 3, 0, 400, 0));
    pending_items.push_back(tick());
    wait_drain();
    cfg_write(REG_IGNORE_CSUM, 32'd1);
    cfg_write(REG_LIFETIME, 32'd1);
    for (int c = 0; c < 9; c++) pending_items.push_back(frag(10 + c, 5, 1, 8, 1));
    pending_items.push_back(tick());
    pending_items.push_back(tick());
    wait_drain();
    cfg_write(REG_LIFETIME, 32'd0);
    cfg_write(REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
    pending_items.push_back(frag(20, 1, 1, 8, 1));
    pending_items.push_back(tick());
    wait_drain();
    cfg_write(REG_LOCAL_ADDRESS, 32'h0A00_0002);
    cfg_write(REG_LIFETIME, 32'd255);
    cfg_write(REG_IGNORE_CSUM, 32'd0);
    hold_off = 300;
    // random: mostly well-formed fragment trains
    n = 0;
    while (n < 200) begin
      if (n == 60) begin
        wait_drain();
        cfg_write(REG_LIFETIME, $urandom_range(2, 6));
        cfg_write(REG_IGNORE_CSUM, $urandom_range(0, 1));
      end
      if (n > 170) calm = 1;
      case ($urandom_range(0, 9))
        0: begin
          pending_items.push_back(noise()); n++;
        end
        1: begin
          pending_items.push_back(tick()); n++;
        end
        default: begin
          s = $urandom_range(0, 3); id = 16'($urandom_range(0, 3));
          o8 = $urandom_range(0, 12); ln = 8 * $urandom_range(0, 5) + $urandom_range(0, 1);
          h = frag(s, id, o8, ln, $urandom_range(0, 3) != 0);
          h.proto = $urandom_range(0, 1) ? 8'd6 : 8'd17;
          h.fo[15:14] = 2'($urandom); h.csok = $urandom_range(0, 15) != 0;
          pending_items.push_back(h); n++;
        end
      endcase
      if (pending_items.size() > 8) wait (pending_items.size() < 4);
    end
    calm = 1;
    wait_drain();
    if (errors == 0) begin
      $display("tb_ip_fragment_reassembly_tracker: done, clean");
    end else begin
      $display("tb_ip_fragment_reassembly_tracker: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_ip_fragment_reassembly_tracker: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fra_pkg.sv
hw/rtl/fra_ram.sv
hw/rtl/fra_fifo.sv
hw/rtl/fra_front.sv
hw/rtl/fra_back.sv
hw/rtl/ip_fragment_reassembly_tracker.sv
dv/tb_ip_fragment_reassembly_tracker.sv
